FILE: src/crc_checked_packet_deframer_defines.svh
// ---------------------------------------------------------------------------
// CRC deframer assertion macros
// Shared concurrent assertion forms for the deframer blocks.
// ---------------------------------------------------------------------------
`ifndef CRC_CHECKED_PACKET_DEFRAMER_DEFINES_SVH
`define CRC_CHECKED_PACKET_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CRCDF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/crcdf_pkg.sv
// ---------------------------------------------------------------------------
// CRC deframer package
// Shared constants and the result beat layout.
// ---------------------------------------------------------------------------
package crcdf_pkg;

  localparam logic [7:0]  START_BYTE = 8'hA1;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  LENGTH_CAP = 8'd200;

  typedef struct packed {
    logic       crc_ok;
    logic       end_of_frame;
    logic       has_data;
    logic [7:0] byte_index;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic [7:0] frame_type;
  } result_t;

endpackage

FILE: src/crcdf_crc16.sv
// ---------------------------------------------------------------------------
// CRC-16 byte update
// One byte step of the reflected CRC-16 (poly 0x8408 form, table-free).
// ---------------------------------------------------------------------------
module crcdf_crc16 (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  logic [7:0] x0;
  logic [7:0] x1;

  assign x0    = byte_i ^ crc_i[7:0];
  assign x1    = x0 ^ {x0[3:0], 4'b0000};
  assign crc_o = {x1, crc_i[15:8]} ^ {12'h000, x1[7:4]} ^ {5'b00000, x1, 3'b000};

endmodule

FILE: src/crcdf_parser.sv
// ---------------------------------------------------------------------------
// Frame parser
// Header state machine, running CRC and per-byte result formation.
// ---------------------------------------------------------------------------
`include "crc_checked_packet_deframer_defines.svh"

module crcdf_parser
  import crcdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] limit_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_LEN,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_PAYLOAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  length_q, length_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  count_q, count_d;

  logic [15:0] crc_seed;
  logic [15:0] crc_next;
  logic [7:0]  count_inc;

  // The type byte restarts the CRC from its initial value.
  assign crc_seed  = (phase_q == PH_TYPE) ? CRC_INIT : crc_q;
  assign count_inc = count_q + 8'd1;

  crcdf_crc16 u_crc (
    .crc_i  (crc_seed),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    length_d    = length_q;
    rx_crc_d    = rx_crc_q;
    crc_d       = crc_q;
    count_d     = count_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.frame_type   = type_q;
    res_o.frame_length = length_q;
    case (phase_q)
      PH_TYPE: begin
        type_d  = byte_i;
        crc_d   = crc_next;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        if (byte_i > limit_i) begin
          phase_d = PH_IDLE;
        end else begin
          length_d = byte_i;
          crc_d    = crc_next;
          phase_d  = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        rx_crc_d = {8'h00, byte_i};
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rx_crc_d = {byte_i, rx_crc_q[7:0]};
        count_d  = 8'd0;
        if (length_q == 8'd0) begin
          phase_d            = PH_IDLE;
          res_valid_o        = 1'b1;
          res_o.end_of_frame = 1'b1;
          res_o.crc_ok       = (crc_q == {byte_i, rx_crc_q[7:0]});
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        crc_d            = crc_next;
        count_d          = count_inc;
        res_valid_o      = 1'b1;
        res_o.data_byte  = byte_i;
        res_o.byte_index = count_q;
        res_o.has_data   = 1'b1;
        if (count_inc == length_q) begin
          phase_d            = PH_IDLE;
          res_o.end_of_frame = 1'b1;
          res_o.crc_ok       = (crc_next == rx_crc_q);
        end
      end
      default: begin
        phase_d = (byte_i == START_BYTE) ? PH_TYPE : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      type_q   <= 8'd0;
      length_q <= 8'd0;
      rx_crc_q <= 16'd0;
      crc_q    <= CRC_INIT;
      count_q  <= 8'd0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      length_q <= length_d;
      rx_crc_q <= rx_crc_d;
      crc_q    <= crc_d;
      count_q  <= count_d;
    end
  end

  // Payload position never reaches the announced length.
  `CRCDF_ASSERT_SAME(a_index_in_frame, clk_i, rst_ni,
    phase_q == PH_PAYLOAD, count_q < length_q, "payload index past frame length")
  // A frame end without data only comes from an empty frame.
  `CRCDF_ASSERT_SAME(a_empty_end, clk_i, rst_ni,
    res_valid_o && !res_o.has_data, res_o.end_of_frame && length_q == 8'd0,
    "data-less result outside an empty frame")
  // A frame end always drops the parser back to hunting for a start byte.
  `CRCDF_ASSERT_NEXT(a_end_to_idle, clk_i, rst_ni,
    fire_i && res_valid_o && res_o.end_of_frame, phase_q == PH_IDLE,
    "parser not idle after frame end")

endmodule

FILE: src/crc_checked_packet_deframer.sv
// An accepted byte waits in the input register until the output register has room, then its
// result beat is loaded into the output register. Throughput, while the consumer takes beats:
// one byte per cycle; the parser and CRC update are a single combinational step.
// Header bytes (bar an empty frame's end) and dropped frames give no beat; each payload byte one.
// Reset (rst_ni low, async): parser hunts for a start byte, CRC = 0xFFFF, max_length = 200,
// and both the input and output registers are emptied.
// ---------------------------------------------------------------------------
// CRC-checked packet deframer
// Cut-through deframer: start byte, type, length, CRC-16 (little endian),
// then payload. Each payload byte is forwarded at once; the frame-ending
// beat carries tlast and the CRC verdict, and the consumer discards
// frames whose verdict is bad.
// ---------------------------------------------------------------------------
module crc_checked_packet_deframer
  import crcdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: max_length
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Receive byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // Result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] frame_type, [15:8] frame_length,
                                        // [23:16] data_byte, [31:24] byte_index
  output logic        m_axis_tlast_o,   // end_of_frame
  output logic [1:0]  m_axis_tuser_o    // [0] has_data, [1] crc_ok
);

  logic [7:0] max_len_q;
  logic [7:0] limit;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_q;

  logic       proc_fire;
  logic       res_valid;
  result_t    res;

  // Config register: always ready; values above the cap behave as the cap.
  assign cfg_ready_o = 1'b1;
  assign limit       = (max_len_q > LENGTH_CAP) ? LENGTH_CAP : max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LENGTH_CAP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Advance the held byte whenever the output register has room for its result.
  assign proc_fire       = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || proc_fire;

  // Input register: capture a beat, drop it once processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_q <= 1'b1;
    end else if (proc_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  crcdf_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (proc_fire),
    .byte_i      (in_byte_q),
    .limit_i     (limit),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output register: load on each processed byte (empty for header bytes),
  // otherwise clear once the consumer takes the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_fire) begin
      out_vld_q <= res_valid;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_q.byte_index, out_q.data_byte,
                            out_q.frame_length, out_q.frame_type};
  assign m_axis_tlast_o  = out_q.end_of_frame;
  assign m_axis_tuser_o  = {out_q.crc_ok, out_q.has_data};

endmodule
